// ----- rtl/rtp_pkg.sv -----
package rtp_pkg;

    localparam int DIVIDEND_W = 18;
    localparam int DIVISOR_W  = 10;
    localparam int DUR_W      = 19;
    localparam int OUT_DATA_W = 40;
    localparam int OCTAVE_SHIFT_DEFAULT = 0;

    localparam logic [DIVIDEND_W-1:0] MS_PER_MINUTE = 18'd60000;
    localparam logic [DIVISOR_W-1:0]  TEMPO_DEFAULT = 10'd63;
    localparam logic [DIVISOR_W-1:0]  DIGIT_SAT_MAX = 10'd999;
    localparam logic [DIVISOR_W-1:0]  DEF_LEN_RESET = 10'd4;
    localparam logic [3:0]            DEF_OCT_RESET = 4'd6;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;

    typedef enum logic [3:0] {
        PH_NAME    = 4'd0,
        PH_HDR_D   = 4'd1,
        PH_D_EQ    = 4'd2,
        PH_D_NUM   = 4'd3,
        PH_HDR_O   = 4'd4,
        PH_O_EQ    = 4'd5,
        PH_O_DIG   = 4'd6,
        PH_O_SEP   = 4'd7,
        PH_HDR_B   = 4'd8,
        PH_B_EQ    = 4'd9,
        PH_B_NUM   = 4'd10,
        PH_N_START = 4'd11,
        PH_N_DIG   = 4'd12,
        PH_N_SHARP = 4'd13,
        PH_N_DOT   = 4'd14,
        PH_N_OCT   = 4'd15
    } phase_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_TEMPO,
        SEQ_EVT_LOAD,
        SEQ_EVENT,
        SEQ_EMIT
    } seq_state_t;

    typedef struct packed {
        phase_t                phase;
        logic [DIVISOR_W-1:0]  acc;
        logic [DIVISOR_W-1:0]  def_len;
        logic [3:0]            def_oct;
        logic [3:0]            pend_semi;
        logic                  pend_dot;
        logic [3:0]            pend_oct;
    } parse_t;

    typedef struct packed {
        logic                  is_rest;
        logic [3:0]            semitone;
        logic [3:0]            octave;
        logic [5:0]            note_index;
        logic                  out_of_range;
        logic [DIVISOR_W-1:0]  divisor;
        logic                  dotted;
        logic                  song_end;
    } evt_t;

    typedef struct packed {
        logic                  evt_valid;
        logic                  tempo_valid;
        logic [DIVISOR_W-1:0]  tempo_bpm;
    } step_ctrl_t;

endpackage

// ----- rtl/rtp_divider.sv -----
module rtp_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rtp_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [rtp_pkg::DIVISOR_W-1:0]   divisor,
    output logic                            busy,
    output logic                            done,
    output logic [rtp_pkg::DIVIDEND_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(rtp_pkg::DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(rtp_pkg::DIVIDEND_W - 1);

    logic [rtp_pkg::DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [rtp_pkg::DIVISOR_W-1:0]  div_reg, div_next;
    logic [rtp_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [rtp_pkg::DIVISOR_W:0]    trial;
    logic [rtp_pkg::DIVISOR_W:0]    diff;

    // One restoring step per cycle: the dividend shifts out of the top of
    // quo_reg while quotient bits shift in at the bottom.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[rtp_pkg::DIVIDEND_W-1]};
        diff      = trial - {1'b0, div_reg};
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            div_next  = divisor;
            quo_next  = dividend;
            cnt_next  = LAST_STEP;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[rtp_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[rtp_pkg::DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[rtp_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[rtp_pkg::DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/rtp_token_decoder.sv -----
module rtp_token_decoder #(
    parameter int OCTAVE_SHIFT = rtp_pkg::OCTAVE_SHIFT_DEFAULT
) (
    input  rtp_pkg::parse_t     cur_state,
    input  logic [7:0]          text_byte,
    input  logic                final_byte,
    output rtp_pkg::parse_t     next_state,
    output rtp_pkg::evt_t       evt,
    output rtp_pkg::step_ctrl_t ctrl
);

    function automatic logic is_dig(input logic [7:0] c);
        return c inside {[rtp_pkg::CH_ZERO:rtp_pkg::CH_NINE]};
    endfunction

    function automatic logic [3:0] letter_code(input logic [7:0] c);
        logic [3:0] code;
        case (c)
            rtp_pkg::CH_C: code = 4'd1;
            rtp_pkg::CH_D: code = 4'd3;
            rtp_pkg::CH_E: code = 4'd5;
            rtp_pkg::CH_F: code = 4'd6;
            rtp_pkg::CH_G: code = 4'd8;
            rtp_pkg::CH_A: code = 4'd10;
            rtp_pkg::CH_B: code = 4'd12;
            default:       code = 4'd0;
        endcase
        return code;
    endfunction

    function automatic logic [rtp_pkg::DIVISOR_W-1:0] acc_digit(
        input logic [rtp_pkg::DIVISOR_W-1:0] acc,
        input logic [7:0]                    c
    );
        logic [13:0] v;
        v = {4'b0, acc} * 14'd10 + {10'b0, c[3:0]};
        if (v > {4'b0, rtp_pkg::DIGIT_SAT_MAX})
            return rtp_pkg::DIGIT_SAT_MAX;
        return v[rtp_pkg::DIVISOR_W-1:0];
    endfunction

    function automatic rtp_pkg::parse_t token_start(
        input rtp_pkg::parse_t s,
        input logic [7:0]      c
    );
        rtp_pkg::parse_t r;
        r           = s;
        r.pend_semi = 4'd0;
        r.pend_dot  = 1'b0;
        r.pend_oct  = s.def_oct;
        if (is_dig(c))
        begin
            r.acc   = {6'b0, c[3:0]};
            r.phase = rtp_pkg::PH_N_DIG;
        end
        else
        begin
            r.acc       = '0;
            r.pend_semi = letter_code(c);
            r.phase     = rtp_pkg::PH_N_SHARP;
        end
        return r;
    endfunction

    rtp_pkg::parse_t st;
    rtp_pkg::parse_t src;
    rtp_pkg::phase_t ph;
    logic            hdr_taken;
    logic            fits;
    logic            emit;
    logic            tempo_req;
    logic [rtp_pkg::DIVISOR_W-1:0] bpm;
    logic [rtp_pkg::DIVISOR_W-1:0] div_sel;
    logic [3:0]      oct;
    logic [7:0]      idx;

    always_comb
    begin
        st        = cur_state;
        ph        = cur_state.phase;
        hdr_taken = 1'b0;
        fits      = 1'b1;
        emit      = 1'b0;
        tempo_req = 1'b0;
        bpm       = rtp_pkg::TEMPO_DEFAULT;

        // Header fields are optional; a letter that does not match falls
        // through to the next field in order.
        if (ph == rtp_pkg::PH_HDR_D)
        begin
            if (text_byte == rtp_pkg::CH_D)
            begin
                st.phase  = rtp_pkg::PH_D_EQ;
                hdr_taken = 1'b1;
            end
            else
                ph = rtp_pkg::PH_HDR_O;
        end
        if (!hdr_taken && ph == rtp_pkg::PH_HDR_O)
        begin
            if (text_byte == rtp_pkg::CH_O)
            begin
                st.phase  = rtp_pkg::PH_O_EQ;
                hdr_taken = 1'b1;
            end
            else
                ph = rtp_pkg::PH_HDR_B;
        end
        if (!hdr_taken && ph == rtp_pkg::PH_HDR_B)
        begin
            if (text_byte == rtp_pkg::CH_B)
            begin
                st.phase  = rtp_pkg::PH_B_EQ;
                hdr_taken = 1'b1;
            end
            else
            begin
                tempo_req = 1'b1;
                ph        = rtp_pkg::PH_N_START;
            end
        end

        if (!hdr_taken)
        begin
            case (ph)
                rtp_pkg::PH_NAME:
                begin
                    if (text_byte == rtp_pkg::CH_COLON)
                        st.phase = rtp_pkg::PH_HDR_D;
                end
                rtp_pkg::PH_D_EQ:
                begin
                    st.acc   = '0;
                    st.phase = rtp_pkg::PH_D_NUM;
                end
                rtp_pkg::PH_D_NUM:
                begin
                    if (is_dig(text_byte))
                        st.acc = acc_digit(st.acc, text_byte);
                    else
                    begin
                        if (st.acc != '0)
                            st.def_len = st.acc;
                        st.acc   = '0;
                        st.phase = rtp_pkg::PH_HDR_O;
                    end
                end
                rtp_pkg::PH_O_EQ:
                    st.phase = rtp_pkg::PH_O_DIG;
                rtp_pkg::PH_O_DIG:
                begin
                    if (text_byte inside {[rtp_pkg::CH_THREE:rtp_pkg::CH_SEVEN]})
                        st.def_oct = text_byte[3:0];
                    st.phase = rtp_pkg::PH_O_SEP;
                end
                rtp_pkg::PH_O_SEP:
                    st.phase = rtp_pkg::PH_HDR_B;
                rtp_pkg::PH_B_EQ:
                begin
                    st.acc   = '0;
                    st.phase = rtp_pkg::PH_B_NUM;
                end
                rtp_pkg::PH_B_NUM:
                begin
                    if (is_dig(text_byte))
                        st.acc = acc_digit(st.acc, text_byte);
                    else
                    begin
                        tempo_req = 1'b1;
                        if (st.acc != '0)
                            bpm = st.acc;
                        st.acc   = '0;
                        st.phase = rtp_pkg::PH_N_START;
                    end
                end
                rtp_pkg::PH_N_START:
                    st = token_start(st, text_byte);
                rtp_pkg::PH_N_DIG:
                begin
                    if (is_dig(text_byte))
                        st.acc = acc_digit(st.acc, text_byte);
                    else
                    begin
                        st.pend_semi = letter_code(text_byte);
                        st.phase     = rtp_pkg::PH_N_SHARP;
                    end
                end
                default:
                begin
                    // Sharp, dot and octave slots of a note token. After an
                    // octave digit the token behaves as if in the dot slot.
                    if (ph == rtp_pkg::PH_N_SHARP && text_byte == rtp_pkg::CH_HASH)
                    begin
                        st.pend_semi = st.pend_semi + 4'd1;
                        st.phase     = rtp_pkg::PH_N_DOT;
                    end
                    else if (ph != rtp_pkg::PH_N_OCT && text_byte == rtp_pkg::CH_DOT)
                    begin
                        st.pend_dot = 1'b1;
                        st.phase    = rtp_pkg::PH_N_OCT;
                    end
                    else if (is_dig(text_byte))
                    begin
                        st.pend_oct = text_byte[3:0];
                        st.phase    = rtp_pkg::PH_N_DOT;
                    end
                    else if (text_byte == rtp_pkg::CH_COMMA)
                    begin
                        emit     = 1'b1;
                        st.phase = rtp_pkg::PH_N_START;
                    end
                    else
                        fits = 1'b0;
                end
            endcase
        end

        // A byte that does not fit closes the token as it stood before it.
        src = fits ? st : cur_state;
        if (!fits)
        begin
            emit = 1'b1;
            if (!final_byte)
                st = token_start(st, text_byte);
        end

        if (final_byte)
        begin
            if (!emit && st.phase >= rtp_pkg::PH_N_DIG)
            begin
                emit = 1'b1;
                src  = st;
            end
            st.phase     = rtp_pkg::PH_NAME;
            st.acc       = '0;
            st.pend_semi = 4'd0;
            st.pend_dot  = 1'b0;
            st.pend_oct  = 4'd0;
        end

        div_sel = (src.acc != '0) ? src.acc : src.def_len;
        if (div_sel == '0)
            div_sel = {{(rtp_pkg::DIVISOR_W-1){1'b0}}, 1'b1};
        oct = src.pend_oct + 4'(OCTAVE_SHIFT);
        // Index is kept offset by 64 so it never goes negative.
        idx = {4'b0, oct} * 8'd12 + {4'b0, src.pend_semi} + 8'd16;

        evt.is_rest      = (src.pend_semi == 4'd0);
        evt.semitone     = src.pend_semi;
        evt.octave       = oct;
        evt.note_index   = idx[5:0];
        evt.out_of_range = (src.pend_semi != 4'd0) && (idx < 8'd65 || idx > 8'd112);
        evt.divisor      = div_sel;
        evt.dotted       = src.pend_dot;
        evt.song_end     = final_byte;

        ctrl.evt_valid   = emit;
        ctrl.tempo_valid = tempo_req;
        ctrl.tempo_bpm   = bpm;

        next_state = st;
    end

endmodule

// ----- rtl/ringtone_text_note_parser.sv -----
// Ringtone text parser: takes a ringtone text one character per transaction
// on the s_ channel and gives one note event per note token on the m_ channel.
// s_tdata carries the character and s_tlast marks the last character of a song.
// m_tdata carries the pitch fields and duration in ms, m_tuser flags a rest,
// and m_tlast marks the event that closes the song.
// Flow: s_tready is high only while the sequencer is idle. A character that
// neither closes a note nor ends the tempo field leaves the sequencer idle.
// A note event runs the shared serial divider (whole-note time / length
// divisor, 18 steps, one quotient bit per cycle); the end of the tempo field,
// or the first byte after a header that lacks b=, runs the same divider for
// 60000 / bpm, then the note division if that character also closes a note.
// The result sits in an output register; a stalled receiver holds it there,
// and the next character is still taken, but a later event waits in the
// sequencer until the register is free.
// Reset puts the parser in the name-skipping phase with default length 4,
// default octave 6 and a whole-note time of zero, and drops any pending output.
module ringtone_text_note_parser #(
    parameter int OCTAVE_SHIFT = rtp_pkg::OCTAVE_SHIFT_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] text_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] semitone, [7:4] octave, [13:8] note_index, [14] index_out_of_range,
    // [33:15] duration_ms, [39:34] zero
    output logic [rtp_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tuser,   // [0] is_rest
    output logic                            m_tlast
);

    localparam rtp_pkg::parse_t PARSE_RESET = '{
        phase:     rtp_pkg::PH_NAME,
        acc:       '0,
        def_len:   rtp_pkg::DEF_LEN_RESET,
        def_oct:   rtp_pkg::DEF_OCT_RESET,
        pend_semi: 4'd0,
        pend_dot:  1'b0,
        pend_oct:  4'd0
    };

    rtp_pkg::seq_state_t seq_reg, seq_next;
    rtp_pkg::parse_t     parse_reg, parse_next;
    rtp_pkg::evt_t       evt_reg, evt_next;
    logic                evt_pend_reg, evt_pend_next;
    logic [rtp_pkg::DIVIDEND_W-1:0] whole_reg, whole_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [rtp_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;

    rtp_pkg::parse_t     dec_state;
    rtp_pkg::evt_t       dec_evt;
    rtp_pkg::step_ctrl_t dec_ctrl;

    logic                           div_start;
    logic [rtp_pkg::DIVIDEND_W-1:0] div_dividend;
    logic [rtp_pkg::DIVISOR_W-1:0]  div_divisor;
    logic                           div_busy;
    logic                           div_done;
    logic [rtp_pkg::DIVIDEND_W-1:0] div_quotient;
    logic [rtp_pkg::DUR_W-1:0]      duration;
    logic                           accept;

    rtp_token_decoder #(
        .OCTAVE_SHIFT (OCTAVE_SHIFT)
    ) u_decoder (
        .cur_state  (parse_reg),
        .text_byte  (s_tdata),
        .final_byte (s_tlast),
        .next_state (dec_state),
        .evt        (dec_evt),
        .ctrl       (dec_ctrl)
    );

    rtp_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign s_tready = (seq_reg == rtp_pkg::SEQ_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign duration = {1'b0, div_quotient}
                    + (evt_reg.dotted ? {2'b0, div_quotient[rtp_pkg::DIVIDEND_W-1:1]}
                                      : '0);

    always_comb
    begin
        seq_next      = seq_reg;
        parse_next    = parse_reg;
        evt_next      = evt_reg;
        evt_pend_next = evt_pend_reg;
        whole_next    = whole_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        div_start     = 1'b0;
        div_dividend  = whole_reg;
        div_divisor   = evt_reg.divisor;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (seq_reg)
            rtp_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    parse_next    = dec_state;
                    evt_next      = dec_evt;
                    evt_pend_next = dec_ctrl.evt_valid;
                    if (dec_ctrl.tempo_valid)
                    begin
                        div_start    = 1'b1;
                        div_dividend = rtp_pkg::MS_PER_MINUTE;
                        div_divisor  = dec_ctrl.tempo_bpm;
                        seq_next     = rtp_pkg::SEQ_TEMPO;
                    end
                    else if (dec_ctrl.evt_valid)
                    begin
                        div_start   = 1'b1;
                        div_divisor = dec_evt.divisor;
                        seq_next    = rtp_pkg::SEQ_EVENT;
                    end
                end
            end
            rtp_pkg::SEQ_TEMPO:
            begin
                if (div_done)
                begin
                    // Whole note is four beats.
                    whole_next = {div_quotient[rtp_pkg::DIVIDEND_W-3:0], 2'b00};
                    seq_next   = evt_pend_reg ? rtp_pkg::SEQ_EVT_LOAD : rtp_pkg::SEQ_IDLE;
                end
            end
            rtp_pkg::SEQ_EVT_LOAD:
            begin
                div_start = 1'b1;
                seq_next  = rtp_pkg::SEQ_EVENT;
            end
            rtp_pkg::SEQ_EVENT:
            begin
                if (div_done)
                    seq_next = rtp_pkg::SEQ_EMIT;
            end
            rtp_pkg::SEQ_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, duration, evt_reg.out_of_range,
                                     evt_reg.note_index, evt_reg.octave,
                                     evt_reg.semitone};
                    m_tuser_next  = evt_reg.is_rest;
                    m_tlast_next  = evt_reg.song_end;
                    seq_next      = rtp_pkg::SEQ_IDLE;
                end
            end
            default:
                seq_next = rtp_pkg::SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= rtp_pkg::SEQ_IDLE;
            parse_reg    <= PARSE_RESET;
            evt_pend_reg <= 1'b0;
            whole_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            seq_reg      <= seq_next;
            parse_reg    <= parse_next;
            evt_pend_reg <= evt_pend_next;
            whole_reg    <= whole_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_reg     <= evt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_busy)
        else $error("divider busy while parser accepts characters");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (seq_reg == rtp_pkg::SEQ_TEMPO || seq_reg == rtp_pkg::SEQ_EVENT))
        else $error("divider finished outside a division state");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == rtp_pkg::SEQ_EMIT && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("event not loaded into output register");

    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

// ----- test/ringtone_text_note_parser_tb.sv -----
module ringtone_text_note_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          OCTAVE_SHIFT   = 0;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned RANDOM_ITEMS   = 1700;
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned BPM_IF_ZERO    = 63;
    localparam int unsigned MS_PER_MIN     = 60000;
    localparam int unsigned DIGIT_CAP      = 999;
    localparam logic [7:0]  CH_EQUALS      = "=";

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [rtp_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    typedef struct packed {
        logic        is_rest;
        logic [3:0]  semitone;
        logic [3:0]  octave;
        logic [5:0]  note_index;
        logic        out_of_range;
        logic [18:0] duration_ms;
        logic        song_end;
    } note_t;

    note_t       expected_notes[$];
    logic [7:0]  song_buf[$];
    int          errors      = 0;
    int unsigned items_sent  = 0;
    bit          no_idle     = 1'b0;
    int unsigned rx_hold_len = 0;

    // Parser state as the predictor sees it.
    rtp_pkg::phase_t phase;
    logic [9:0]  digits;
    logic [9:0]  def_len;
    logic [3:0]  def_oct;
    logic [17:0] whole_ms;
    logic [3:0]  tok_semi;
    logic        tok_dotted;
    logic [3:0]  tok_oct;

    ringtone_text_note_parser #(
        .OCTAVE_SHIFT(OCTAVE_SHIFT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit is_digit(logic [7:0] c);
        return c >= rtp_pkg::CH_ZERO && c <= rtp_pkg::CH_NINE;
    endfunction

    function automatic logic [9:0] add_digit(logic [9:0] acc, logic [7:0] c);
        int unsigned v;
        v = acc * 10 + 32'(c - rtp_pkg::CH_ZERO);
        return (v > DIGIT_CAP) ? 10'(DIGIT_CAP) : v[9:0];
    endfunction

    function automatic logic [3:0] letter_code(logic [7:0] c);
        case (c)
            rtp_pkg::CH_C: return 4'd1;
            rtp_pkg::CH_D: return 4'd3;
            rtp_pkg::CH_E: return 4'd5;
            rtp_pkg::CH_F: return 4'd6;
            rtp_pkg::CH_G: return 4'd8;
            rtp_pkg::CH_A: return 4'd10;
            rtp_pkg::CH_B: return 4'd12;
            default:       return 4'd0;
        endcase
    endfunction

    function automatic void set_tempo(logic [9:0] bpm);
        int unsigned beats;
        beats = (bpm == 0) ? BPM_IF_ZERO : 32'(bpm);
        whole_ms = 18'((MS_PER_MIN / beats) * 4);
    endfunction

    function automatic note_t build_note(bit at_end);
        int unsigned div;
        int unsigned dur;
        int unsigned idx;
        logic [3:0]  oct;
        note_t       n;
        div = 32'((digits != 0) ? digits : def_len);
        if (div == 0)
            div = 1;
        dur = whole_ms / div;
        if (tok_dotted)
            dur = dur + dur / 2;
        oct = 4'(tok_oct + OCTAVE_SHIFT);
        // Offset by 64 so that octaves below 4 stay positive.
        idx = oct * 12 + tok_semi + 16;
        n.is_rest      = (tok_semi == 0);
        n.semitone     = tok_semi;
        n.octave       = oct;
        n.note_index   = idx[5:0];
        n.out_of_range = !n.is_rest && (idx < 65 || idx > 112);
        n.duration_ms  = dur[18:0];
        n.song_end     = at_end;
        return n;
    endfunction

    function automatic void start_token(logic [7:0] c);
        tok_semi   = 4'd0;
        tok_dotted = 1'b0;
        tok_oct    = def_oct;
        if (is_digit(c))
        begin
            digits = 10'(c - rtp_pkg::CH_ZERO);
            phase  = rtp_pkg::PH_N_DIG;
        end
        else
        begin
            digits   = 10'd0;
            tok_semi = letter_code(c);
            phase    = rtp_pkg::PH_N_SHARP;
        end
    endfunction

    function automatic void predict_notes(logic [7:0] c, bit fin);
        rtp_pkg::phase_t ph;
        bit         taken;
        bit         emit;
        bit         fits;
        ph    = phase;
        taken = 1'b0;
        emit  = 1'b0;
        fits  = 1'b1;
        // Header keys are optional; a missing one falls through to the next.
        if (ph == rtp_pkg::PH_HDR_D)
        begin
            if (c == rtp_pkg::CH_D)
            begin
                phase = rtp_pkg::PH_D_EQ;
                taken = 1'b1;
            end
            else
                ph = rtp_pkg::PH_HDR_O;
        end
        if (!taken && ph == rtp_pkg::PH_HDR_O)
        begin
            if (c == rtp_pkg::CH_O)
            begin
                phase = rtp_pkg::PH_O_EQ;
                taken = 1'b1;
            end
            else
                ph = rtp_pkg::PH_HDR_B;
        end
        if (!taken && ph == rtp_pkg::PH_HDR_B)
        begin
            if (c == rtp_pkg::CH_B)
            begin
                phase = rtp_pkg::PH_B_EQ;
                taken = 1'b1;
            end
            else
            begin
                set_tempo(10'(BPM_IF_ZERO));
                ph = rtp_pkg::PH_N_START;
            end
        end
        if (!taken)
        begin
            case (ph)
                rtp_pkg::PH_NAME:
                    if (c == rtp_pkg::CH_COLON)
                        phase = rtp_pkg::PH_HDR_D;
                rtp_pkg::PH_D_EQ:
                begin
                    digits = 10'd0;
                    phase  = rtp_pkg::PH_D_NUM;
                end
                rtp_pkg::PH_D_NUM:
                    if (is_digit(c))
                        digits = add_digit(digits, c);
                    else
                    begin
                        if (digits != 0)
                            def_len = digits;
                        digits = 10'd0;
                        phase  = rtp_pkg::PH_HDR_O;
                    end
                rtp_pkg::PH_O_EQ:
                    phase = rtp_pkg::PH_O_DIG;
                rtp_pkg::PH_O_DIG:
                begin
                    if (c >= rtp_pkg::CH_THREE && c <= rtp_pkg::CH_SEVEN)
                        def_oct = 4'(c - rtp_pkg::CH_ZERO);
                    phase = rtp_pkg::PH_O_SEP;
                end
                rtp_pkg::PH_O_SEP:
                    phase = rtp_pkg::PH_HDR_B;
                rtp_pkg::PH_B_EQ:
                begin
                    digits = 10'd0;
                    phase  = rtp_pkg::PH_B_NUM;
                end
                rtp_pkg::PH_B_NUM:
                    if (is_digit(c))
                        digits = add_digit(digits, c);
                    else
                    begin
                        set_tempo(digits);
                        digits = 10'd0;
                        phase  = rtp_pkg::PH_N_START;
                    end
                rtp_pkg::PH_N_START:
                    start_token(c);
                rtp_pkg::PH_N_DIG:
                    if (is_digit(c))
                        digits = add_digit(digits, c);
                    else
                    begin
                        tok_semi = letter_code(c);
                        phase    = rtp_pkg::PH_N_SHARP;
                    end
                default:
                    if (ph == rtp_pkg::PH_N_SHARP && c == rtp_pkg::CH_HASH)
                    begin
                        tok_semi = tok_semi + 4'd1;
                        phase    = rtp_pkg::PH_N_DOT;
                    end
                    else if (ph != rtp_pkg::PH_N_OCT && c == rtp_pkg::CH_DOT)
                    begin
                        tok_dotted = 1'b1;
                        phase      = rtp_pkg::PH_N_OCT;
                    end
                    else if (is_digit(c))
                    begin
                        // After an octave digit only '.', another digit or ','
                        // still fit the token, just as in the dot slot.
                        tok_oct = 4'(c - rtp_pkg::CH_ZERO);
                        phase   = rtp_pkg::PH_N_DOT;
                    end
                    else if (c == rtp_pkg::CH_COMMA)
                    begin
                        expected_notes.push_back(build_note(fin));
                        emit  = 1'b1;
                        phase = rtp_pkg::PH_N_START;
                    end
                    else
                        fits = 1'b0;
            endcase
        end
        // A byte that fits no slot closes the token and, unless it is the final byte, opens the next one.
        if (!fits)
        begin
            expected_notes.push_back(build_note(fin));
            emit = 1'b1;
            if (!fin)
                start_token(c);
        end
        if (fin)
        begin
            if (!emit && phase >= rtp_pkg::PH_N_DIG)
                expected_notes.push_back(build_note(1'b1));
            phase      = rtp_pkg::PH_NAME;
            digits     = 10'd0;
            tok_semi   = 4'd0;
            tok_dotted = 1'b0;
            tok_oct    = 4'd0;
        end
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [7:0] any_digit();
        return 8'(rtp_pkg::CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_number(int unsigned max_len);
        repeat ($urandom_range(0, max_len))
            song_buf.push_back(any_digit());
    endfunction

    // Mostly well-formed songs with random content, some broken, some noise.
    function automatic void build_song();
        string       letters = "cdefgabp";
        int unsigned count;
        int unsigned ending;
        song_buf.delete();
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 30))
                song_buf.push_back(any_byte());
            return;
        end
        repeat ($urandom_range(0, 4))
            song_buf.push_back(($urandom_range(0, 5) == 0) ? any_byte()
                                : 8'($urandom_range(rtp_pkg::CH_A, 8'h7A)));
        song_buf.push_back(rtp_pkg::CH_COLON);
        if ($urandom_range(0, 3) != 0)
        begin
            song_buf.push_back(rtp_pkg::CH_D);
            song_buf.push_back(CH_EQUALS);
            add_number(4);
            song_buf.push_back(($urandom_range(0, 7) == 0) ? any_byte()
                                                            : rtp_pkg::CH_COMMA);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            song_buf.push_back(rtp_pkg::CH_O);
            song_buf.push_back(CH_EQUALS);
            song_buf.push_back(($urandom_range(0, 3) == 0) ? any_digit()
                                : 8'(rtp_pkg::CH_THREE + $urandom_range(0, 4)));
            song_buf.push_back(rtp_pkg::CH_COMMA);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            song_buf.push_back(rtp_pkg::CH_B);
            song_buf.push_back(CH_EQUALS);
            add_number(4);
            song_buf.push_back(($urandom_range(0, 7) == 0) ? any_byte()
                                                            : rtp_pkg::CH_COLON);
        end
        count = $urandom_range(1, 8);
        for (int n = 0; n < count; n++)
        begin
            add_number(($urandom_range(0, 9) == 0) ? 4 : 2);
            song_buf.push_back(($urandom_range(0, 9) == 0) ? any_byte()
                                                            : letters[$urandom_range(0, 7)]);
            if ($urandom_range(0, 3) == 0)
                song_buf.push_back(rtp_pkg::CH_HASH);
            if ($urandom_range(0, 3) == 0)
                song_buf.push_back(rtp_pkg::CH_DOT);
            if ($urandom_range(0, 1) == 0)
                song_buf.push_back(any_digit());
            if (n != count - 1)
                song_buf.push_back(($urandom_range(0, 9) == 0) ? any_byte()
                                                                : rtp_pkg::CH_COMMA);
        end
        ending = $urandom_range(0, 2);
        if (ending == 1)
            song_buf.push_back(rtp_pkg::CH_COMMA);
        else if (ending == 2)
            song_buf.push_back(any_byte());
    endfunction

    task automatic send_char(input logic [7:0] ch, input bit last);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_notes(ch, last);
        items_sent++;
    endtask

    task automatic send_text(input string txt, input bit ends_song);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], ends_song && (i == txt.len() - 1));
    endtask

    // Sender stays quiet until every predicted note event has been taken.
    task automatic drain_notes();
        s_tvalid <= 1'b0;
        while (expected_notes.size() != 0)
            @(posedge clk);
    endtask

    // Last byte in the name, last byte in the header, and a first note that
    // ends the song, all with the reset defaults.
    task automatic test_song_boundaries();
        send_text("z", 1'b1);
        send_text("n:d", 1'b1);
        send_text("r:c", 1'b1);
    endtask

    // Slowest tempo and shortest divisor give the longest dotted note; a zero
    // byte in the letter slot followed by '#' becomes a pitched note, and a
    // final byte that does not fit is dropped.
    task automatic test_extreme_notes();
        send_text("h:d=1,o=3,b=1:1a.,0p,", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(rtp_pkg::CH_HASH, 1'b0);
        send_char(rtp_pkg::CH_B, 1'b1);
    endtask

    // d=0 and o=8 are ignored, b=0 means 63, the duration digits saturate and
    // unterminated tokens are closed by the next byte.
    task automatic test_odd_headers();
        send_text("s:d=0,o=8,b=0:9999g#.9 c", 1'b1);
    endtask

    task automatic test_output_backpressure();
        no_idle     = 1'b1;
        rx_hold_len = LONG_HOLD;
        send_text("bp:d=8,o=5,b=200:c,d,e,f,g,a,b,c#,d#,16e", 1'b1);
        no_idle = 1'b0;
    endtask

    task automatic test_random_songs();
        int unsigned stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            build_song();
            foreach (song_buf[i])
                send_char(song_buf[i], i == song_buf.size() - 1);
            if ($urandom_range(0, 9) == 0)
                drain_notes();
        end
        no_idle = 1'b0;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : note_checker
        note_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_notes.size() == 0)
            begin
                $error("unexpected note event: tdata %h tuser %b tlast %b",
                       m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                want = expected_notes.pop_front();
                check_field("is_rest", 32'(want.is_rest), 32'(m_tuser));
                check_field("semitone", 32'(want.semitone), 32'(m_tdata[3:0]));
                check_field("octave", 32'(want.octave), 32'(m_tdata[7:4]));
                check_field("note_index", 32'(want.note_index), 32'(m_tdata[13:8]));
                check_field("index_out_of_range", 32'(want.out_of_range),
                            32'(m_tdata[14]));
                check_field("duration_ms", 32'(want.duration_ms), 32'(m_tdata[33:15]));
                check_field("song_end", 32'(want.song_end), 32'(m_tlast));
            end
        end
    end

    initial
    begin : result_sink
        int unsigned stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            stall = 0;
            if (rx_hold_len != 0)
            begin
                stall       = rx_hold_len;
                rx_hold_len = 0;
            end
            else if (m_tvalid && m_tready)
                stall = draw_gap();
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        phase      = rtp_pkg::PH_NAME;
        digits     = 10'd0;
        def_len    = rtp_pkg::DEF_LEN_RESET;
        def_oct    = rtp_pkg::DEF_OCT_RESET;
        whole_ms   = 18'd0;
        tok_semi   = 4'd0;
        tok_dotted = 1'b0;
        tok_oct    = 4'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_song_boundaries();
        drain_notes();
        test_extreme_notes();
        drain_notes();
        test_odd_headers();
        drain_notes();
        test_output_backpressure();
        drain_notes();
        test_random_songs();
        drain_notes();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rtp_pkg.sv
rtl/rtp_divider.sv
rtl/rtp_token_decoder.sv
rtl/ringtone_text_note_parser.sv
test/ringtone_text_note_parser_tb.sv
